// ===== hw/rtl/skin_pixel_green_mean_core_macros.svh =====
// Assertion helpers; expect clk and rst_n in scope.
`ifndef SKIN_PIXEL_GREEN_MEAN_CORE_MACROS_SVH
`define SKIN_PIXEL_GREEN_MEAN_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SPGM_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define SPGM_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define SPGM_ASSERT_IMP(lbl, pre, post)
`define SPGM_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// ===== hw/rtl/spgm_pkg.sv =====
`default_nettype none
package spgm_pkg;
  localparam int MAX_PIXELS = 65536;
  localparam int CNT_W      = 17;
  localparam int SUM_W      = 25;
  localparam int MEAN_W     = 16;
  localparam int QDEPTH     = 8;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int DIV_STEPS  = SUM_W + 8;

  localparam logic [1:0] REG_HUE_LOW  = 2'd0;
  localparam logic [1:0] REG_HUE_HIGH = 2'd1;
  localparam logic [1:0] REG_SAT_MIN  = 2'd2;

  typedef struct packed {
    logic       skin;
    logic [7:0] green;
    logic       last;
  } item_t;
endpackage
`default_nettype wire

// ===== hw/rtl/spgm_queue.sv =====
`default_nettype none
module spgm_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire spgm_pkg::item_t din,
  input  wire logic          pop,
  output spgm_pkg::item_t    dout,
  output logic               not_empty,
  output logic [spgm_pkg::QCNT_W-1:0] count
);
  import spgm_pkg::*;
  `include "skin_pixel_green_mean_core_macros.svh"

  localparam int PTR_W = $clog2(QDEPTH);

  item_t              mem_r [QDEPTH];
  logic [PTR_W-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_pop;

  assign do_pop    = pop && (cnt_r != '0);
  assign dout      = mem_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  `SPGM_ASSERT_IMP(a_no_overflow, push, cnt_r < QCNT_W'(QDEPTH) || do_pop)
  `SPGM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= QCNT_W'(QDEPTH))
  `SPGM_ASSERT_NXT(a_cnt_track, push && !do_pop, cnt_r == $past(cnt_r) + 1'b1)
endmodule
`default_nettype wire

// ===== hw/rtl/spgm_front.sv =====
`default_nettype none
module spgm_front (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_addr,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_blue,
  input  wire logic [7:0] in_green,
  input  wire logic [7:0] in_red,
  input  wire logic       in_last,
  input  wire logic [spgm_pkg::QCNT_W-1:0] q_count,
  output logic            q_push,
  output spgm_pkg::item_t q_din
);
  import spgm_pkg::*;

  logic [7:0] hue_low_r, hue_high_r, sat_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_low_r  <= 8'd14;
      hue_high_r <= 8'd165;
      sat_min_r  <= 8'd50;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HUE_LOW:  hue_low_r  <= cfg_wdata;
        REG_HUE_HIGH: hue_high_r <= cfg_wdata;
        REG_SAT_MIN:  sat_min_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic acc;
  logic v1_r, v2_r;
  assign in_full = (QCNT_W'(q_count) + QCNT_W'(v1_r) + QCNT_W'(v2_r)) >= QCNT_W'(QDEPTH);
  assign acc     = in_push && !in_full;

  // stage 1: extrema, lightness, saturation denominator, hue numerator
  logic [7:0]  mx, mn, d, lum, den, k;
  logic [8:0]  s;
  logic [15:0] num;
  logic signed [17:0] t;
  logic [16:0] k_prod;

  always_comb begin
    mx = in_red;
    mn = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx)  mx = in_blue;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn)  mn = in_blue;
    d   = mx - mn;
    s   = {1'b0, mx} + {1'b0, mn};
    lum = 8'((s + 9'd1) >> 1);
    den = (s < 9'd255) ? s[7:0] : 8'(10'd510 - {1'b0, s});
    k_prod = 17'(lum) * 17'd171;
    k   = 8'(k_prod >> 9) + 8'd1;
    if (mx == in_red) begin
      t = 18'sd30 * ($signed({10'd0, in_green}) - $signed({10'd0, in_blue}));
      if (t < 0) t = t + 18'sd180 * $signed({10'd0, d});
    end else if (mx == in_green) begin
      t = 18'sd30 * ($signed({10'd0, in_blue}) - $signed({10'd0, in_red}))
        + 18'sd60 * $signed({10'd0, d});
    end else begin
      t = 18'sd30 * ($signed({10'd0, in_red}) - $signed({10'd0, in_green}))
        + 18'sd120 * $signed({10'd0, d});
    end
    num = t[15:0];
  end

  logic [7:0]  d1_r, den1_r, lum1_r, k1_r, g1_r;
  logic [15:0] num1_r;
  logic        last1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_r    <= d;
    den1_r  <= den;
    lum1_r  <= lum;
    k1_r    <= k;
    g1_r    <= in_green;
    num1_r  <= num;
    last1_r <= in_last;
  end

  // stage 2: scaled thresholds
  logic [17:0] a2_r, pl2_r, ph2_r, p360_r, ss2_r, psm2_r, plum2_r, pk2_r;
  logic        nz2_r, hz2_r, last2_r;
  logic [7:0]  g2_r;

  always_ff @(posedge clk) begin
    a2_r    <= 18'({num1_r, 1'b0}) + 18'(d1_r);
    pl2_r   <= 18'(d1_r) * (18'(hue_low_r) + 18'd1) * 18'd2;
    ph2_r   <= 18'(d1_r) * 18'(hue_high_r) * 18'd2;
    p360_r  <= 18'(d1_r) * 18'd360;
    ss2_r   <= 18'(d1_r) * 18'd510 + 18'(den1_r);
    psm2_r  <= 18'(den1_r) * 18'(sat_min_r) * 18'd2;
    plum2_r <= 18'(den1_r) * 18'(lum1_r) * 18'd4;
    pk2_r   <= 18'(den1_r) * 18'(k1_r) * 18'd2;
    nz2_r   <= (d1_r != 8'd0);
    hz2_r   <= (hue_high_r == 8'd0);
    g2_r    <= g1_r;
    last2_r <= last1_r;
  end

  // stage 3: compares, straight into the queue
  logic wrap, low_ok, high_ok;
  always_comb begin
    wrap    = a2_r >= p360_r;
    low_ok  = wrap || (a2_r < pl2_r);
    high_ok = wrap ? hz2_r : (a2_r >= ph2_r);
    q_din.skin  = nz2_r && (low_ok || high_ok) && (ss2_r >= psm2_r)
                  && (ss2_r < plum2_r) && (ss2_r >= pk2_r);
    q_din.green = g2_r;
    q_din.last  = last2_r;
  end
  assign q_push = v2_r;
endmodule
`default_nettype wire

// ===== hw/rtl/spgm_back.sv =====
`default_nettype none
module spgm_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_not_empty,
  input  wire spgm_pkg::item_t q_dout,
  output logic                 q_pop,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output logic [15:0]          out_mean_green,
  output logic [16:0]          out_skin_pixels,
  output logic                 out_empty_res
);
  import spgm_pkg::*;
  `include "skin_pixel_green_mean_core_macros.svh"

  localparam logic ST_ACC = 1'b0;
  localparam logic ST_DIV = 1'b1;
  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  logic                 st_r, st_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [CNT_W-1:0]     tot_r, tot_nxt;
  logic [SUM_W+7:0]     dvd_r, dvd_nxt;
  logic [CNT_W:0]       rem_r, rem_nxt;
  logic [MEAN_W-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0]     dvs_r, dvs_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 ov_r, ov_nxt;
  logic [MEAN_W-1:0]    mean_r, mean_nxt;
  logic [CNT_W-1:0]     cnt_out_r, cnt_out_nxt;
  logic                 er_r, er_nxt;
  logic                 add;
  logic [SUM_W-1:0]     sum_new;
  logic [CNT_W-1:0]     tot_new;
  logic [CNT_W:0]       trial;

  assign out_empty       = !ov_r;
  assign out_mean_green  = mean_r;
  assign out_skin_pixels = cnt_out_r;
  assign out_empty_res   = er_r;

  always_comb begin
    st_nxt      = st_r;
    sum_nxt     = sum_r;
    tot_nxt     = tot_r;
    dvd_nxt     = dvd_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    dvs_nxt     = dvs_r;
    step_nxt    = step_r;
    ov_nxt      = ov_r && !out_pop;
    mean_nxt    = mean_r;
    cnt_out_nxt = cnt_out_r;
    er_nxt      = er_r;
    q_pop       = 1'b0;
    add         = q_dout.skin && (tot_r < CNT_W'(MAX_PIXELS));
    sum_new     = add ? sum_r + SUM_W'(q_dout.green) : sum_r;
    tot_new     = add ? tot_r + 1'b1 : tot_r;
    trial       = {rem_r[CNT_W-1:0], dvd_r[SUM_W+7]};
    unique case (st_r)
      ST_ACC: begin
        if (q_not_empty && !(q_dout.last && ov_r && !out_pop)) begin
          q_pop = 1'b1;
          if (q_dout.last) begin
            sum_nxt = '0;
            tot_nxt = '0;
            if (tot_new == '0) begin
              ov_nxt      = 1'b1;
              mean_nxt    = '0;
              cnt_out_nxt = '0;
              er_nxt      = 1'b1;
            end else begin
              st_nxt      = ST_DIV;
              dvd_nxt     = {sum_new, 8'd0};
              dvs_nxt     = tot_new;
              rem_nxt     = '0;
              quo_nxt     = '0;
              step_nxt    = '0;
              cnt_out_nxt = tot_new;
            end
          end else begin
            sum_nxt = sum_new;
            tot_nxt = tot_new;
          end
        end
      end
      ST_DIV: begin
        dvd_nxt  = dvd_r << 1;
        step_nxt = step_r + 1'b1;
        if (trial >= {1'b0, dvs_r}) begin
          rem_nxt = trial - {1'b0, dvs_r};
          quo_nxt = {quo_r[MEAN_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          quo_nxt = {quo_r[MEAN_W-2:0], 1'b0};
        end
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          st_nxt   = ST_ACC;
          ov_nxt   = 1'b1;
          mean_nxt = quo_nxt;
          er_nxt   = 1'b0;
        end
      end
      default: st_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_ACC;
      sum_r <= '0;
      tot_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      sum_r <= sum_nxt;
      tot_r <= tot_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    dvs_r     <= dvs_nxt;
    step_r    <= step_nxt;
    mean_r    <= mean_nxt;
    cnt_out_r <= cnt_out_nxt;
    er_r      <= er_nxt;
  end

  `SPGM_ASSERT_IMP(a_div_out_free, st_r == ST_DIV, !ov_r)
  `SPGM_ASSERT_IMP(a_tot_bound, 1'b1, tot_r <= CNT_W'(MAX_PIXELS))
  `SPGM_ASSERT_IMP(a_no_pop_in_div, st_r == ST_DIV, !q_pop)
  `SPGM_ASSERT_IMP(a_rem_bound, st_r == ST_DIV, rem_r < {1'b0, dvs_r})
endmodule
`default_nettype wire

// ===== hw/rtl/skin_pixel_green_mean_core.sv =====
// Pixel pipeline: classifies into the queue, one pixel per cycle sustained while in_full is low.
// Accumulation takes one pixel per cycle from an 8-deep queue, except during a divide or while a result waits.
// A last pixel starts a restoring divide of the green sum, scaled by 256, by the skin count;
// an empty region gives its result without a divide.
// Pixels after a last one queue up during the divide; input stalls once 8 are held in the queue and pipeline.
// Synchronous active-low reset: limits 14/165/50, sums cleared, queue empty.
`default_nettype none
module skin_pixel_green_mean_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_blue,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_red,
  input  wire logic        in_last,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [15:0]      out_mean_green,
  output logic [16:0]      out_skin_pixels,
  output logic             out_empty_res
);
  import spgm_pkg::*;

  logic               q_push, q_pop, q_not_empty;
  item_t              q_din, q_dout;
  logic [QCNT_W-1:0]  q_count;

  spgm_front u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_push(in_push), .in_full(in_full),
    .in_blue(in_blue), .in_green(in_green), .in_red(in_red), .in_last(in_last),
    .q_count(q_count), .q_push(q_push), .q_din(q_din)
  );

  spgm_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .din(q_din), .pop(q_pop),
    .dout(q_dout), .not_empty(q_not_empty), .count(q_count)
  );

  spgm_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_not_empty(q_not_empty), .q_dout(q_dout), .q_pop(q_pop),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_mean_green(out_mean_green), .out_skin_pixels(out_skin_pixels),
    .out_empty_res(out_empty_res)
  );
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import spgm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_blue = '0, in_green = '0, in_red = '0;
  logic        in_last = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [15:0] out_mean_green;
  logic [16:0] out_skin_pixels;
  logic        out_empty_res;

  typedef struct packed {
    logic [15:0] mean;
    logic [16:0] count;
    logic        none;
  } region_mean_t;

  region_mean_t expected_means[$];
  logic [7:0]   hue_lo, hue_hi, sat_min;
  logic [24:0]  green_acc;
  logic [16:0]  skin_acc;
  int           mismatches = 0;
  longint       cycles = 0;
  int           idle_pct = 30;
  int           stall_pct = 30;
  int           stall_left = 0;

  localparam longint CYCLE_LIMIT = 3000000;

  skin_pixel_green_mean_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int rnd_gap();
    if ($urandom_range(99) < 90) return $urandom_range(3);
    return $urandom_range(40, 8);
  endfunction

  // HLS classification in exact integers
  function automatic bit pixel_is_skin(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int mx, mn, d, s, lum, sat, hue, num, den;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    s = mx + mn;
    lum = (s + 1) / 2;
    sat = 0;
    hue = 0;
    if (d > 0) begin
      den = (s < 255) ? s : 510 - s;
      sat = (2 * 255 * d + den) / (2 * den);
      if (mx == r) begin
        num = 30 * (g - b);
        if (num < 0) num += 180 * d;
      end else if (mx == g) begin
        num = 30 * (b - r) + 60 * d;
      end else begin
        num = 30 * (r - g) + 120 * d;
      end
      hue = (2 * num + d) / (2 * d);
      if (hue >= 180) hue -= 180;
    end
    return (hue <= hue_lo || hue >= hue_hi) && sat >= sat_min
        && 2 * lum > sat && lum < 3 * sat;
  endfunction

  function automatic void accumulate_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                           logic lst);
    region_mean_t res;
    logic [32:0] scaled;
    if (pixel_is_skin(b, g, r) && skin_acc < MAX_PIXELS) begin
      green_acc += g;
      skin_acc += 1;
    end
    if (lst) begin
      if (skin_acc == 0) begin
        res = '{mean: '0, count: '0, none: 1'b1};
      end else begin
        scaled = {green_acc, 8'd0};
        res.mean = 16'(scaled / skin_acc);
        res.count = skin_acc;
        res.none = 1'b0;
      end
      expected_means = {expected_means, res};
      green_acc = '0;
      skin_acc = '0;
    end
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  // result side: random stalls, compare against oldest expectation
  always @(posedge clk) begin
    region_mean_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_means.size() == 0) begin
        report("unexpected item", out_skin_pixels, 0);
      end else begin
        want = expected_means.pop_front();
        if (out_mean_green !== want.mean) report("mean_green", out_mean_green, want.mean);
        if (out_skin_pixels !== want.count) report("skin_pixels", out_skin_pixels, want.count);
        if (out_empty_res !== want.none) report("empty_res", out_empty_res, want.none);
      end
    end
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_pop <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left <= rnd_gap();
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic lst);
    int gap;
    gap = (idle_pct > 0 && $urandom_range(99) < idle_pct) ? rnd_gap() : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_blue <= b;
    in_green <= g;
    in_red <= r;
    in_last <= lst;
    do @(posedge clk); while (in_full);
    accumulate_pixel(b, g, r, lst);
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_HUE_LOW:  hue_lo = val;
      REG_HUE_HIGH: hue_hi = val;
      REG_SAT_MIN:  sat_min = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [7:0] lo, logic [7:0] hi, logic [7:0] smin);
    wait_drained();
    write_reg(REG_HUE_LOW, lo);
    write_reg(REG_HUE_HIGH, hi);
    write_reg(REG_SAT_MIN, smin);
    cfg_we <= 1'b0;
  endtask

  // skin-like pixel: red dominant, moderate saturation
  task automatic send_skinlike(logic lst);
    logic [7:0] r, g, b;
    r = 8'($urandom_range(255, 90));
    g = 8'($urandom_range(r - 20, r / 3));
    b = 8'($urandom_range(g, g / 3));
    send_pixel(b, g, r, lst);
  endtask

  task automatic send_random_pixel(logic lst);
    if ($urandom_range(99) < 60) send_skinlike(lst);
    else send_pixel(8'($urandom), 8'($urandom), 8'($urandom), lst);
  endtask

  task automatic test_directed();
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);         // empty region
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);   // zero saturation
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd60, 8'd100, 8'd200, 1'b0);
    send_pixel(8'd1, 8'd0, 8'd255, 1'b0);       // hue rounds towards 180
    send_pixel(8'd2, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd3, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd40, 8'd90, 8'd150, 1'b0);
    send_pixel(8'd128, 8'd127, 8'd255, 1'b0);
    send_pixel(8'd100, 8'd130, 8'd160, 1'b1);
    wait_drained();
    cfg_we <= 1'b1;                              // unused index ignored
    cfg_addr <= 2'd3;
    cfg_wdata <= 8'hff;
    @(posedge clk);
    cfg_we <= 1'b0;
    send_pixel(8'd60, 8'd100, 8'd200, 1'b1);
  endtask

  task automatic test_limit_settings();
    set_limits(8'd0, 8'd255, 8'd255);
    repeat (40) send_random_pixel($urandom_range(7) == 0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    set_limits(8'd255, 8'd0, 8'd1);
    repeat (40) send_random_pixel($urandom_range(7) == 0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    set_limits(8'd179, 8'd179, 8'd0);
    repeat (40) send_random_pixel($urandom_range(7) == 0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    set_limits(8'd25, 8'd150, 8'd30);
  endtask

  task automatic test_random_regions();
    int len;
    int n;
    n = 0;
    while (n < 1100) begin
      if ($urandom_range(9) == 0) begin
        idle_pct = 0;
        stall_pct = 0;
      end else begin
        idle_pct = 30;
        stall_pct = 30;
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
      repeat (len - 1) send_random_pixel(1'b0);
      send_random_pixel(1'b1);
      n += len;
    end
    idle_pct = 30;
    stall_pct = 30;
  endtask

  task automatic test_reset_limits();
    set_limits(8'd14, 8'd165, 8'd50);
    repeat (60) send_random_pixel($urandom_range(5) == 0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
  endtask

  initial begin
    hue_lo = 8'd14;
    hue_hi = 8'd165;
    sat_min = 8'd50;
    green_acc = '0;
    skin_acc = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limit_settings();
    test_random_regions();
    test_reset_limits();
    wait_drained();
    if (mismatches == 0 && expected_means.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
